@@ hw/rtl/dq_pkg.sv @@
// Shared constants, request codes and controller/datapath types for the deque.
package dq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned INDEX_W       = 6;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned S_TDATA_W     = 40;
  localparam int unsigned M_TDATA_W     = 40;

  // Request codes carried in the slave tuser
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;

  // Result status codes carried in the master tuser
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Physical operations on the ring; "hi" is the end past the last slot
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH_HI,
    OP_PUSH_LO,
    OP_POP_HI,
    OP_POP_LO,
    OP_READ,
    OP_REVERSE
  } dq_op_e;

  typedef struct packed {
    logic                load;
    dq_op_e              op;
    logic [STATUS_W-1:0] status;
  } dq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_bad;
    logic rev;
  } dq_stat_t;

endpackage

@@ hw/rtl/dq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dq_ctrl.sv @@
// Deque controller: request handshake, output hold state and operation decode.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dq_stat_t         stat_i,
  output dq_cmd_t          cmd_o
);

  localparam logic [0:0] OUT_IDLE = 1'b0;
  localparam logic [0:0] OUT_HOLD = 1'b1;

  logic [0:0] state_q, state_d;
  logic       accept;

  // Take a new request whenever the result slot is free or being drained
  assign in_ready_o  = (state_q == OUT_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == OUT_HOLD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      OUT_IDLE: begin
        if (accept) state_d = OUT_HOLD;
      end
      OUT_HOLD: begin
        if (out_ready_i && !accept) state_d = OUT_IDLE;
      end
      default: state_d = OUT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OUT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Map logical request to a physical ring operation; reverse swaps the ends
  always_comb begin
    cmd_o.load   = accept;
    cmd_o.op     = OP_NOP;
    cmd_o.status = ST_OK;
    unique case (req_type_i)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (stat_i.full) begin
          cmd_o.status = ST_FULL;
        end else if ((req_type_i == REQ_PUSH_BACK) != stat_i.rev) begin
          cmd_o.op = OP_PUSH_HI;
        end else begin
          cmd_o.op = OP_PUSH_LO;
        end
      end
      REQ_POP_BACK, REQ_POP_FRONT: begin
        if (stat_i.empty) begin
          cmd_o.status = ST_EMPTY;
        end else if ((req_type_i == REQ_POP_BACK) != stat_i.rev) begin
          cmd_o.op = OP_POP_HI;
        end else begin
          cmd_o.op = OP_POP_LO;
        end
      end
      REQ_READ: begin
        if (stat_i.idx_bad) begin
          cmd_o.status = ST_RANGE;
        end else begin
          cmd_o.op = OP_READ;
        end
      end
      REQ_REVERSE: cmd_o.op = OP_REVERSE;
      default:     cmd_o.op = OP_NOP;
    endcase
    if (!accept) begin
      cmd_o.op = OP_NOP;
    end
  end

endmodule

@@ hw/rtl/dq_datapath.sv @@
// Deque datapath: ring pointers, entry count, reverse flag, store and result registers.
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dq_cmd_t             cmd_i,
  input  logic [VALUE_W-1:0]  push_value_i,
  input  logic [INDEX_W-1:0]  read_index_i,
  output dq_stat_t            stat_o,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [AW:0]   DepthW = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [AW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic                rev_q, rev_d;
  logic                rd_ok_q;
  logic [EW-1:0]       count_q_ext, count_d_ext, idx_ext, off_ext;
  logic [AW-1:0]       front_dec, hi_slot, rd_slot;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_rdata;
  logic [COUNT_W-1:0]  out_count_q;
  logic [STATUS_W-1:0] out_status_q;

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DepthW) s = s - DepthW;
    return s[AW-1:0];
  endfunction

  assign count_q_ext = EW'(count_q);
  assign count_d_ext = EW'(count_d);
  assign idx_ext     = EW'(read_index_i);

  assign stat_o.full    = (count_q == DepthC);
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.idx_bad = (idx_ext >= count_q_ext);
  assign stat_o.rev     = rev_q;

  // Reversed reads count back from the high end
  assign off_ext   = rev_q ? (count_q_ext - EW'(1) - idx_ext) : idx_ext;
  assign rd_slot   = slot_add(front_q, off_ext[AW-1:0]);
  assign hi_slot   = slot_add(front_q, count_q[AW-1:0]);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : (front_q - AW'(1));

  assign ram_we    = (cmd_i.op == OP_PUSH_HI) || (cmd_i.op == OP_PUSH_LO);
  assign ram_waddr = (cmd_i.op == OP_PUSH_LO) ? front_dec : hi_slot;
  assign ram_re    = (cmd_i.op == OP_READ);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    rev_d   = rev_q;
    unique case (cmd_i.op)
      OP_PUSH_HI: count_d = count_q + CW'(1);
      OP_PUSH_LO: begin
        front_d = front_dec;
        count_d = count_q + CW'(1);
      end
      OP_POP_HI:  count_d = count_q - CW'(1);
      OP_POP_LO: begin
        front_d = slot_add(front_q, AW'(1));
        count_d = count_q - CW'(1);
      end
      OP_REVERSE: rev_d = ~rev_q;
      OP_NOP, OP_READ: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      if (cmd_i.load) begin
        rd_ok_q <= ram_re;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_count_q  <= count_d_ext[COUNT_W-1:0];
      out_status_q <= cmd_i.status;
    end
  end

  dq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_value_i),
    .re_i    (ram_re),
    .raddr_i (rd_slot),
    .rdata_o (ram_rdata)
  );

  assign read_value_o  = rd_ok_q ? ram_rdata : '0;
  assign entry_count_o = out_count_q;
  assign status_o      = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count exceeds capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PUSH_HI || cmd_i.op == OP_PUSH_LO) |=>
      count_q == $past(count_q) + CW'(1))
    else $error("push did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP_HI || cmd_i.op == OP_POP_LO) |=>
      count_q == $past(count_q) - CW'(1))
    else $error("pop did not remove one entry");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && cmd_i.status != ST_OK) |-> (!ram_we && count_d == count_q
      && front_d == front_q))
    else $error("rejected request changed the queue");
`endif

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue with stream request and result channels.
//
// Usage:
//   Each request enters on the slave stream: tuser carries the request type
//   (push back, push front, pop back, pop front, read at index, reverse),
//   tdata carries the push value and the read index. Every request gives
//   exactly one result on the master stream: tdata carries the read value
//   and the entry count after the request, tuser the status (ok, full,
//   empty, index out of range). Rejected requests change nothing.
//   Latency: a result is valid the cycle after its request is accepted.
//   Throughput: one request per cycle while the receiver takes results; the
//   ring store has one write and one read port, used by pushes and by reads.
//   Reverse toggles a flag that swaps the ends and the index direction.
//   When the receiver stalls, the result holds in the output register and
//   tready stays high only while that register is being drained.
//   Reset empties the queue and clears the reverse flag at once; the store
//   itself is not cleared and is only read at entries already pushed.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // push_value [31:0], read_index [37:32], zero pad [39:38]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [REQ_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // read_value [31:0], entry_count [38:32], zero pad [39]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [STATUS_W-1:0]  m_axis_tuser
);

  dq_cmd_t             cmd;
  dq_stat_t            stat;
  logic [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]  entry_count;

  // Decode requests and hold the result handshake
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Ring pointers, count, store and result registers
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .push_value_i  (s_axis_tdata[VALUE_W-1:0]),
    .read_index_i  (s_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W]),
    .stat_o        (stat),
    .read_value_o  (read_value),
    .entry_count_o (entry_count),
    .status_o      (m_axis_tuser)
  );

  // Pack the result fields, lowest field first, zero-fill to whole bytes
  assign m_axis_tdata = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, entry_count, read_value};

endmodule

@@ verif/tb_double_ended_queue.sv @@
// Self-checking stream testbench for double_ended_queue: directed and random requests.
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned LONG_HOLD    = 200;  // cycles the receiver holds off once
  localparam int unsigned HOLD_AFTER   = 300;  // requests accepted before that hold starts
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTS   = 40;

  // Request codes the block treats as no operation
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef enum int unsigned {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_EVEN
  } phase_e;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    int unsigned        gap;    // idle cycles the sender inserts before this request
  } dq_item_t;

  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } dq_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [REQ_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be sent, and results still owed by the block
  dq_item_t   request_queue[$];
  dq_result_t awaited_results[$];

  // Shadow copy of the deque: ring memory, front slot, entry count, reverse flag
  logic [VALUE_W-1:0] ring_mem [DEPTH];
  int unsigned        ring_front = 0;
  int unsigned        ring_count = 0;
  logic               ring_rev = 1'b0;

  // Entry count as the stimulus generator expects it; steers index choice and phases
  int unsigned plan_count = 0;

  int unsigned err_count = 0;
  int unsigned requests_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned n_push = 0, n_pop = 0, n_read = 0, n_rev = 0, n_spare = 0;
  int unsigned hit_full = 0, hit_empty = 0, hit_range = 0, peak_count = 0;
  int unsigned hold_left = 0;
  logic        hold_started = 1'b0;
  logic        input_stalled = 1'b0;  // sender offered while the block refused during the long hold-off

  // Print one line per mismatch, keeping the log short when things go badly wrong
  task automatic flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Apply one request to the shadow deque and return the result it must produce
  task automatic deque_apply(input dq_item_t r, output dq_result_t e);
    int unsigned off;
    e.value  = '0;
    e.status = ST_OK;
    case (r.kind)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (ring_count >= DEPTH) begin
          e.status = ST_FULL;
        end else begin
          // Reverse swaps which physical end is the logical back
          if ((r.kind == REQ_PUSH_BACK) != ring_rev) begin
            ring_mem[(ring_front + ring_count) % DEPTH] = r.value;
          end else begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            ring_mem[ring_front] = r.value;
          end
          ring_count++;
        end
      end
      REQ_POP_BACK, REQ_POP_FRONT: begin
        if (ring_count == 0) begin
          e.status = ST_EMPTY;
        end else begin
          if ((r.kind == REQ_POP_BACK) == ring_rev) ring_front = (ring_front + 1) % DEPTH;
          ring_count--;
        end
      end
      REQ_READ: begin
        if (r.index >= ring_count) begin
          e.status = ST_RANGE;
        end else begin
          // While reversed, indices run from the physical high end down
          off = ring_rev ? (ring_count - 1 - r.index) : r.index;
          e.value = ring_mem[(ring_front + off) % DEPTH];
        end
      end
      REQ_REVERSE: ring_rev = !ring_rev;
      default: ;
    endcase
    e.count = ring_count[COUNT_W-1:0];
  endtask

  // Queue one request and track the entry count it leaves behind
  function automatic void add_request(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value,
                                      input logic [INDEX_W-1:0] index, input int unsigned gap);
    dq_item_t r;
    r.kind  = kind;
    r.value = value;
    r.index = index;
    r.gap   = gap;
    request_queue.insert(request_queue.size(), r);
    if ((kind == REQ_PUSH_BACK || kind == REQ_PUSH_FRONT) && plan_count < DEPTH) plan_count++;
    if ((kind == REQ_POP_BACK || kind == REQ_POP_FRONT) && plan_count > 0) plan_count--;
  endfunction

  // Idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range indices, with the last entry, the first and out-of-range ones mixed in
  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (plan_count == 0 || roll >= 85) return INDEX_W'($urandom_range(0, DEPTH - 1));
    if (roll < 35) return INDEX_W'($urandom_range(0, plan_count - 1));
    if (roll < 55) return INDEX_W'(plan_count - 1);
    if (roll < 65) return '0;
    if (plan_count < DEPTH) return INDEX_W'($urandom_range(plan_count, DEPTH - 1));
    return INDEX_W'(DEPTH - 1);
  endfunction

  // Fill phases lean to pushes, drain phases to pops, so the deque swings between full and empty
  function automatic logic [REQ_W-1:0] pick_kind(input phase_e phase);
    int unsigned roll, push_pct;
    roll = $urandom_range(0, 99);
    if (roll < 2)  return ($urandom_range(0, 1) != 0) ? REQ_SPARE_7 : REQ_SPARE_6;
    if (roll < 7)  return REQ_REVERSE;
    if (roll < 22) return REQ_READ;
    push_pct = (phase == PHASE_FILL) ? 85 : (phase == PHASE_DRAIN) ? 15 : 50;
    if ($urandom_range(0, 99) < push_pct)
      return ($urandom_range(0, 1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    return ($urandom_range(0, 1) != 0) ? REQ_POP_FRONT : REQ_POP_BACK;
  endfunction

  // Driver: present the next request once the previous one is taken, after its idle gap
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    dq_item_t nxt;
    int unsigned gap_left;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_left = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        nxt = request_queue[0];
        request_queue.delete(0);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.kind;
        // push_value [31:0], read_index [37:32], zero pad above
        s_axis_tdata  <= {{(S_TDATA_W - VALUE_W - INDEX_W){1'b0}}, nxt.index, nxt.value};
        gap_left = request_queue.size() != 0 ? request_queue[0].gap : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: start once, after enough traffic, and count it down here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      hold_started <= 1'b0;
    end else if (!hold_started && requests_accepted >= HOLD_AFTER) begin
      hold_left    <= LONG_HOLD;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls and the long hold-off, with quiet stretches that start no new random stall
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    int unsigned stall_left;
    int unsigned cyc;
    logic quiet_rx;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      cyc        = 0;
      quiet_rx   = 1'b0;
    end else begin
      cyc++;
      if (cyc % 128 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_rx && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted request, check every accepted result against the oldest
  always @(posedge clk_i) begin : watch_streams
    dq_item_t   req;
    dq_result_t want;
    dq_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && !s_axis_tready && hold_left != 0) input_stalled <= 1'b1;
      if (s_axis_tvalid && s_axis_tready) begin
        req.kind  = s_axis_tuser;
        req.value = s_axis_tdata[VALUE_W-1:0];
        req.index = s_axis_tdata[VALUE_W +: INDEX_W];
        req.gap   = 0;
        deque_apply(req, want);
        awaited_results.insert(awaited_results.size(), want);
        requests_accepted <= requests_accepted + 1;
        case (req.kind)
          REQ_PUSH_BACK, REQ_PUSH_FRONT: n_push++;
          REQ_POP_BACK, REQ_POP_FRONT:   n_pop++;
          REQ_READ:                      n_read++;
          REQ_REVERSE:                   n_rev++;
          default:                       n_spare++;
        endcase
        case (want.status)
          ST_FULL:  hit_full++;
          ST_EMPTY: hit_empty++;
          ST_RANGE: hit_range++;
          default: ;
        endcase
        if (want.count > peak_count) peak_count = want.count;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        // read_value [31:0], entry_count [38:32]
        got.value  = m_axis_tdata[VALUE_W-1:0];
        got.count  = m_axis_tdata[VALUE_W +: COUNT_W];
        got.status = m_axis_tuser;
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with no request outstanding",
                        64'({got.count, got.value}), '0);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          results_checked++;
          if (got.value !== want.value)
            flag_mismatch("read_value", 64'(got.value), 64'(want.value));
          if (got.count !== want.count)
            flag_mismatch("entry_count", 64'(got.count), 64'(want.count));
          if (got.status !== want.status)
            flag_mismatch("status", 64'(got.status), 64'(want.status));
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    phase_e      phase;
    int unsigned phase_len;
    int unsigned planned;
    logic        quiet_tx;
    logic [REQ_W-1:0] kind;

    // Directed: empty-queue errors, spare codes, value extremes, reads around the count
    add_request(REQ_READ,       pick_value(), 6'd0,  0);
    add_request(REQ_POP_BACK,   pick_value(), 6'd63, 0);
    add_request(REQ_POP_FRONT,  pick_value(), 6'd0,  0);
    add_request(REQ_SPARE_6,    32'hFFFF_FFFF, 6'd63, 0);
    add_request(REQ_SPARE_7,    32'h0000_0000, 6'd0,  0);
    add_request(REQ_PUSH_BACK,  32'h7FFF_FFFF, 6'd0,  0);
    add_request(REQ_PUSH_FRONT, 32'h8000_0000, 6'd0,  0);
    add_request(REQ_PUSH_BACK,  32'h0000_0000, 6'd63, 0);
    add_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0,  0);
    add_request(REQ_READ,       pick_value(), 6'd0,  0);
    add_request(REQ_READ,       pick_value(), 6'd3,  0);
    add_request(REQ_READ,       pick_value(), 6'd4,  0);
    add_request(REQ_READ,       pick_value(), 6'd63, 0);
    // Reversed: ends and index direction swap
    add_request(REQ_REVERSE,    pick_value(), 6'd0,  0);
    add_request(REQ_READ,       pick_value(), 6'd0,  0);
    add_request(REQ_READ,       pick_value(), 6'd3,  0);
    add_request(REQ_PUSH_BACK,  32'h0000_0005, 6'd0, 0);
    add_request(REQ_PUSH_FRONT, 32'h0000_0006, 6'd0, 0);
    add_request(REQ_READ,       pick_value(), 6'd5,  0);
    add_request(REQ_POP_FRONT,  pick_value(), 6'd0,  0);
    add_request(REQ_POP_BACK,   pick_value(), 6'd0,  0);
    add_request(REQ_REVERSE,    pick_value(), 6'd0,  0);
    add_request(REQ_READ,       pick_value(), 6'd1,  0);

    // Random: phases that fill, drain or mix, so full and empty are both reached often
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      phase     = phase_e'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 90);
      quiet_tx  = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        kind = pick_kind(phase);
        add_request(kind, pick_value(), pick_index(), quiet_tx ? 0 : pick_gap());
        if (kind != REQ_SPARE_6 && kind != REQ_SPARE_7) planned++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge so the check sees settled values
    do @(negedge clk_i);
    while (request_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d requests: %0d pushes, %0d pops, %0d reads, %0d reverses, %0d spare codes",
             requests_accepted, n_push, n_pop, n_read, n_rev, n_spare);
    $display("Rejects seen: %0d full, %0d empty, %0d out of range; peak count %0d; input stall %0s",
             hit_full, hit_empty, hit_range, peak_count, input_stalled ? "reached" : "missed");
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("double_ended_queue test failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
verif/tb_double_ended_queue.sv
